[sv/grib2_message_deframer_macros.svh]
// assertion macros shared by the deframer rtl
// each macro expands to one labeled concurrent assertion on clk / rst_n
`ifndef GRIB2_MESSAGE_DEFRAMER_MACROS_SVH
`define GRIB2_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define GMD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gmd_pkg.sv]
// types, constants and the mark scanner step for the grib2 message deframer
// no dependencies; used by gmd_out_queue and grib2_message_deframer
package gmd_pkg;

  localparam int LENGTH_BITS = 40;
  localparam int OFFSET_BITS = 48;
  localparam int COUNT_BITS  = 16;
  // room for section length plus offset without wrap
  localparam int SUM_BITS    = (LENGTH_BITS > 32) ? LENGTH_BITS + 1 : 33;

  localparam logic [7:0] CH_G        = 8'd71;
  localparam logic [7:0] CH_R        = 8'd82;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_B        = 8'd66;
  localparam logic [7:0] CH_END      = 8'd55;
  localparam logic [7:0] SECT_DATA   = 8'd7;
  localparam logic [7:0] EDITION     = 8'd2;
  localparam logic [7:0] EDITION_ONE = 8'd1;
  localparam logic [31:0] SECT_MIN   = 32'd5;
  localparam int HDR_SIZE            = 16;
  localparam logic [63:0] MIN_MSG    = 64'd20;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_END       = 4'd1;
  localparam logic [3:0] ST_ED1       = 4'd2;
  localparam logic [3:0] ST_SHORT     = 4'd3;
  localparam logic [3:0] ST_WIDE      = 4'd4;
  localparam logic [3:0] ST_TRUNC     = 4'd5;
  localparam logic [3:0] ST_NO_END    = 4'd6;
  localparam logic [3:0] ST_SHORT_SEC = 4'd7;
  localparam logic [3:0] ST_OVERRUN   = 4'd8;
  localparam logic [3:0] ST_MISALIGN  = 4'd9;
  localparam logic [3:0] ST_NONE      = 4'd0;

  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_WANT_R = 3'd1;
  localparam logic [2:0] PH_WANT_I = 3'd2;
  localparam logic [2:0] PH_WANT_B = 3'd3;
  localparam logic [2:0] PH_HEADER = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [3:0]             status;
    logic [OFFSET_BITS-1:0] message_offset;
    logic [LENGTH_BITS-1:0] message_length;
    logic [COUNT_BITS-1:0]  submessage_count;
  } out_t;

  typedef struct packed {
    logic [2:0] ph;
    logic       hit;  // byte is a G that opens a new candidate
    logic       adv;  // byte extended the mark
  } scan_t;

  // one step of the "GRIB" mark matcher from a seek or want phase
  function automatic scan_t mark_step(input logic [2:0] ph, input logic [7:0] b);
    scan_t      s;
    logic [7:0] want;
    s = '{ph: PH_SEEK, hit: 1'b0, adv: 1'b0};
    case (ph)
      PH_WANT_R: want = CH_R;
      PH_WANT_I: want = CH_I;
      PH_WANT_B: want = CH_B;
      default:   want = CH_G;
    endcase
    if ((ph inside {PH_WANT_R, PH_WANT_I, PH_WANT_B}) && b == want) begin
      s.ph  = ph + 3'd1;
      s.adv = 1'b1;
    end else if (b == CH_G) begin
      s.ph  = PH_WANT_R;
      s.hit = 1'b1;
    end
    return s;
  endfunction

endpackage

[sv/gmd_out_queue.sv]
// two-slot result queue: head register plus skid register
// depends on gmd_pkg for the result word type
module gmd_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gmd_pkg::out_t push_word,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output gmd_pkg::out_t out_data
);

  logic          head_vld_r, head_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  gmd_pkg::out_t head_r, head_nxt;
  gmd_pkg::out_t skid_r, skid_nxt;
  logic          take;

  assign take = head_vld_r && !out_stall;

  always_comb begin
    head_vld_nxt = head_vld_r;
    head_nxt     = head_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || take) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        head_nxt     = push_word;
        head_vld_nxt = push;
      end
    end else if (push) begin
      // head is stalled, park the new word
      skid_nxt     = push_word;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

endmodule

[sv/grib2_message_deframer.sv]
// grib2 message deframer top level: byte parser and result queue
// depends on gmd_pkg, gmd_out_queue and grib2_message_deframer_macros.svh

// Takes one stream byte per cycle while in_stall is low and reports one result
// word per GRIB edition 2 message (offset of the leading G, declared length,
// section 7 count, status), per skipped edition 1 message, per rejected length
// and per end of stream. A byte is parsed from the input register and its result
// word is registered in the output register, or in the skid register while the
// output register is stalled. Throughput is one byte per clock; in_stall rises
// only when both result slots (output register and skid register) hold words
// that the consumer has not taken, and then only while a word waits in the input
// register. There is no clearing pass after reset.
module grib2_message_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gmd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gmd_pkg::out_t out_data
);

  localparam int L = gmd_pkg::LENGTH_BITS;
  localparam int P = gmd_pkg::OFFSET_BITS;
  localparam int C = gmd_pkg::COUNT_BITS;
  localparam int S = gmd_pkg::SUM_BITS;

  // input register
  logic         in_vld_r;
  gmd_pkg::in_t in_word_r;

  // parser state
  logic [2:0]   phase_r, phase_nxt;
  logic [7:0]   rep_r [4];
  logic [7:0]   rep_nxt [4];
  logic [3:0]   hidx_r, hidx_nxt;
  logic [63:0]  lacc_r, lacc_nxt;
  logic [P-1:0] pos_r, pos_nxt;
  logic [P-1:0] start_r, start_nxt;
  logic [L-1:0] boff_r, boff_nxt;
  logic [L-1:0] nso_r, nso_nxt;
  logic [L-1:0] lm4_r, lm4_nxt;
  logic [L-1:0] lm1_r, lm1_nxt;
  logic [31:0]  slen_r, slen_nxt;
  logic [C-1:0] cnt_r, cnt_nxt;
  logic [3:0]   werr_r, werr_nxt;
  logic         endok_r, endok_nxt;

  logic          proc_go;
  logic          res_vld;
  gmd_pkg::out_t res;
  logic          q_full;
  logic [L-1:0]  len_w;

  assign len_w    = lacc_r[L-1:0];
  assign in_stall = in_vld_r && q_full;
  assign proc_go  = in_vld_r && !q_full;

  always_comb begin
    logic [7:0]     b;
    gmd_pkg::scan_t sc;
    logic [7:0]     rb [4];
    logic [63:0]    lacc_v;
    logic [L-1:0]   len_v;
    logic [L-1:0]   dfull;
    logic [L-1:0]   rem;
    logic [S-1:0]   sum;
    logic [3:0]     st;
    logic           endok_v;
    b          = in_word_r.data_byte;
    phase_nxt  = phase_r;
    rep_nxt    = rep_r;
    hidx_nxt   = hidx_r;
    lacc_nxt   = lacc_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    boff_nxt   = boff_r;
    nso_nxt    = nso_r;
    lm4_nxt    = lm4_r;
    lm1_nxt    = lm1_r;
    slen_nxt   = slen_r;
    cnt_nxt    = cnt_r;
    werr_nxt   = werr_r;
    endok_nxt  = endok_r;
    res_vld    = 1'b0;
    res        = '0;
    sc         = '0;
    rb         = rep_r;
    lacc_v     = {lacc_r[55:0], b};
    len_v      = lacc_v[L-1:0];
    dfull      = boff_r - nso_r;
    rem        = len_w - nso_r;
    sum        = S'(nso_r) + S'(slen_r);
    st         = gmd_pkg::ST_OK;
    endok_v    = endok_r;

    if (in_word_r.end_of_stream) begin
      res_vld = 1'b1;
      if (phase_r == gmd_pkg::PH_BODY) begin
        res.status         = gmd_pkg::ST_TRUNC;
        res.message_offset = start_r;
        res.message_length = len_w;
      end else begin
        res.status = gmd_pkg::ST_END;
      end
      phase_nxt = gmd_pkg::PH_SEEK;
      for (int k = 0; k < 4; k++) rep_nxt[k] = 8'd0;
      hidx_nxt  = 4'd0;
      lacc_nxt  = 64'd0;
      pos_nxt   = '0;
      start_nxt = '0;
      boff_nxt  = '0;
      nso_nxt   = L'(gmd_pkg::HDR_SIZE);
      lm4_nxt   = '0;
      lm1_nxt   = '0;
      slen_nxt  = 32'd0;
      cnt_nxt   = '0;
      werr_nxt  = gmd_pkg::ST_NONE;
      endok_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + P'(1);
      case (phase_r)
        gmd_pkg::PH_HEADER: begin
          if (hidx_r < 4'd4) begin
            rep_nxt[hidx_r[1:0]] = b;
            if (hidx_r == 4'd3 && b == gmd_pkg::EDITION_ONE) begin
              phase_nxt          = gmd_pkg::PH_SEEK;
              res_vld            = 1'b1;
              res.status         = gmd_pkg::ST_ED1;
              res.message_offset = start_r;
            end else if (hidx_r == 4'd3 && b != gmd_pkg::EDITION) begin
              // unknown edition: rescan the four header bytes as stream bytes
              rb[3]     = b;
              phase_nxt = gmd_pkg::PH_SEEK;
              for (int k = 0; k < 4; k++) begin
                sc        = gmd_pkg::mark_step(phase_nxt, rb[k]);
                phase_nxt = sc.ph;
                if (sc.hit) start_nxt = start_r + P'(4 + k);
                if (sc.adv) begin
                  hidx_nxt = 4'd0;
                  lacc_nxt = 64'd0;
                end
              end
            end else begin
              hidx_nxt = hidx_r + 4'd1;
            end
          end else begin
            lacc_nxt = lacc_v;
            if (hidx_r >= 4'd11) begin
              phase_nxt = gmd_pkg::PH_SEEK;
              if (lacc_v < gmd_pkg::MIN_MSG) begin
                res_vld            = 1'b1;
                res.status         = gmd_pkg::ST_SHORT;
                res.message_offset = start_r;
                res.message_length = len_v;
              end else if ((lacc_v >> L) != 64'd0) begin
                res_vld            = 1'b1;
                res.status         = gmd_pkg::ST_WIDE;
                res.message_offset = start_r;
                res.message_length = '1;
              end else begin
                phase_nxt = gmd_pkg::PH_BODY;
                boff_nxt  = L'(gmd_pkg::HDR_SIZE);
                nso_nxt   = L'(gmd_pkg::HDR_SIZE);
                lm4_nxt   = len_v - L'(4);
                lm1_nxt   = len_v - L'(1);
                slen_nxt  = 32'd0;
                cnt_nxt   = '0;
                werr_nxt  = gmd_pkg::ST_NONE;
                endok_nxt = 1'b1;
              end
            end else begin
              hidx_nxt = hidx_r + 4'd1;
            end
          end
        end
        gmd_pkg::PH_BODY: begin
          // section walk: 4 length bytes then the section number byte
          if (werr_r == gmd_pkg::ST_NONE && nso_r < lm4_r && boff_r >= nso_r
              && dfull <= L'(4)) begin
            if (dfull[2:0] == 3'd0) begin
              slen_nxt = {24'd0, b};
            end else if (dfull[2:0] != 3'd4) begin
              slen_nxt = {slen_r[23:0], b};
            end else begin
              if (b == gmd_pkg::SECT_DATA && cnt_r != '1) cnt_nxt = cnt_r + C'(1);
              if (slen_r < gmd_pkg::SECT_MIN) begin
                werr_nxt = gmd_pkg::ST_SHORT_SEC;
              end else if (S'(slen_r) > S'(rem)) begin
                werr_nxt = gmd_pkg::ST_OVERRUN;
              end else begin
                nso_nxt = sum[L-1:0];
              end
            end
          end
          if (boff_r >= lm4_r && b != gmd_pkg::CH_END) endok_v = 1'b0;
          endok_nxt = endok_v;
          if (boff_r >= lm1_r) begin
            if (!endok_v) begin
              st = gmd_pkg::ST_NO_END;
            end else if (werr_nxt != gmd_pkg::ST_NONE) begin
              st = werr_nxt;
            end else if (nso_nxt != lm4_r) begin
              st = gmd_pkg::ST_MISALIGN;
            end else begin
              st = gmd_pkg::ST_OK;
            end
            res_vld              = 1'b1;
            res.status           = st;
            res.message_offset   = start_r;
            res.message_length   = len_w;
            res.submessage_count = (st == gmd_pkg::ST_OK) ? cnt_nxt : '0;
            phase_nxt            = gmd_pkg::PH_SEEK;
          end else begin
            boff_nxt = boff_r + L'(1);
          end
        end
        default: begin
          sc        = gmd_pkg::mark_step(phase_r, b);
          phase_nxt = sc.ph;
          if (sc.hit) start_nxt = pos_r;
          if (sc.adv) begin
            hidx_nxt = 4'd0;
            lacc_nxt = 64'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= gmd_pkg::PH_SEEK;
      for (int k = 0; k < 4; k++) rep_r[k] <= 8'd0;
      hidx_r   <= 4'd0;
      lacc_r   <= 64'd0;
      pos_r    <= '0;
      start_r  <= '0;
      boff_r   <= '0;
      nso_r    <= L'(gmd_pkg::HDR_SIZE);
      lm4_r    <= '0;
      lm1_r    <= '0;
      slen_r   <= 32'd0;
      cnt_r    <= '0;
      werr_r   <= gmd_pkg::ST_NONE;
      endok_r  <= 1'b1;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (proc_go) begin
        phase_r <= phase_nxt;
        rep_r   <= rep_nxt;
        hidx_r  <= hidx_nxt;
        lacc_r  <= lacc_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        boff_r  <= boff_nxt;
        nso_r   <= nso_nxt;
        lm4_r   <= lm4_nxt;
        lm1_r   <= lm1_nxt;
        slen_r  <= slen_nxt;
        cnt_r   <= cnt_nxt;
        werr_r  <= werr_nxt;
        endok_r <= endok_nxt;
      end
    end
    if (!in_stall) in_word_r <= in_data;
  end

  gmd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (proc_go && res_vld),
    .push_word (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`include "grib2_message_deframer_macros.svh"

  `GMD_ASSERT_IMPL(a_skid_needs_head, q_full, out_valid, "skid word without head word")
  `GMD_ASSERT_NEXT(a_parked_result_kept, proc_go && res_vld && out_valid && out_stall, q_full, "stalled result dropped")
  `GMD_ASSERT_IMPL(a_body_offset_in_range, phase_r == gmd_pkg::PH_BODY, boff_r < len_w, "body offset past message end")
  `GMD_ASSERT_IMPL(a_section_walk_in_range, phase_r == gmd_pkg::PH_BODY, nso_r <= len_w, "section walk past message end")

endmodule

[dv/testbench.sv]
// self-checking bench for grib2_message_deframer: directed and random byte streams
// each result word is predicted by an in-bench model of the message framing and checked in order
// depends on gmd_pkg and the deframer rtl
module testbench;

  localparam int HOLD_CYCLES = 200;
  localparam int TIMEOUT     = 4_000_000;
  localparam int ITEM_TARGET = 800;

  typedef enum int {
    FLAW_NONE, FLAW_NO_END, FLAW_SHORT_SEC, FLAW_OVERRUN, FLAW_MISALIGN, FLAW_CUT
  } flaw_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  gmd_pkg::in_t  in_data = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  gmd_pkg::out_t out_data;

  grib2_message_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // framing tracker state
  logic [2:0]                      trk_phase;
  logic [7:0]                      hdr_bytes [4];
  logic [3:0]                      hdr_count;
  logic [63:0]                     len_acc;
  logic [gmd_pkg::OFFSET_BITS-1:0] stream_pos;
  logic [gmd_pkg::OFFSET_BITS-1:0] msg_start;
  logic [63:0]                     body_pos;
  logic [63:0]                     next_sect;
  logic [31:0]                     sect_len_acc;
  logic [gmd_pkg::COUNT_BITS-1:0]  data_sects;
  logic [3:0]                      walk_fault;
  logic                            tail_ok;

  gmd_pkg::out_t due_reports [$];
  logic [7:0]    burst [$];
  int unsigned   words_sent = 0;
  int unsigned   reports_due_total = 0;
  int unsigned   reports_checked = 0;
  int unsigned   input_stall_cycles = 0;
  int unsigned   mismatches = 0;
  int unsigned   status_hits [16];
  bit            send_gaps = 1'b1;
  bit            recv_gaps = 1'b1;
  bit            hold_request = 1'b0;

  function automatic gmd_pkg::out_t make_report(
      input logic [3:0]                      st,
      input logic [gmd_pkg::OFFSET_BITS-1:0] off,
      input logic [63:0]                     len,
      input logic [gmd_pkg::COUNT_BITS-1:0]  cnt);
    gmd_pkg::out_t r;
    r.status           = st;
    r.message_offset   = off;
    r.message_length   = len[gmd_pkg::LENGTH_BITS-1:0];
    r.submessage_count = cnt;
    return r;
  endfunction

  task automatic tracker_clear();
    trk_phase    = gmd_pkg::PH_SEEK;
    hdr_bytes    = '{4{8'd0}};
    hdr_count    = '0;
    len_acc      = '0;
    stream_pos   = '0;
    msg_start    = '0;
    body_pos     = '0;
    next_sect    = 64'(gmd_pkg::HDR_SIZE);
    sect_len_acc = '0;
    data_sects   = '0;
    walk_fault   = gmd_pkg::ST_NONE;
    tail_ok      = 1'b1;
  endtask

  task automatic hunt_g(input logic [7:0] b, input logic [gmd_pkg::OFFSET_BITS-1:0] pos);
    trk_phase = gmd_pkg::PH_SEEK;
    if (b == gmd_pkg::CH_G) begin
      trk_phase = gmd_pkg::PH_WANT_R;
      msg_start = pos;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic [gmd_pkg::OFFSET_BITS-1:0] pos,
                           output bit got, output gmd_pkg::out_t rep, output bit rescan);
    logic [7:0]  tail_char;
    logic [63:0] o, lim, nx, d, sl;
    logic [3:0]  st;
    got    = 1'b0;
    rescan = 1'b0;
    rep    = '0;
    case (trk_phase)
      gmd_pkg::PH_WANT_R, gmd_pkg::PH_WANT_I, gmd_pkg::PH_WANT_B: begin
        case (trk_phase)
          gmd_pkg::PH_WANT_R: tail_char = gmd_pkg::CH_R;
          gmd_pkg::PH_WANT_I: tail_char = gmd_pkg::CH_I;
          default:            tail_char = gmd_pkg::CH_B;
        endcase
        if (b == tail_char) begin
          trk_phase = trk_phase + 3'd1;
          hdr_count = '0;
          len_acc   = '0;
        end else begin
          hunt_g(b, pos);
        end
      end
      gmd_pkg::PH_HEADER: begin
        if (hdr_count < 4'd4) begin
          hdr_bytes[hdr_count[1:0]] = b;
          if (hdr_count == 4'd3 && b == gmd_pkg::EDITION_ONE) begin
            trk_phase = gmd_pkg::PH_SEEK;
            got = 1'b1;
            rep = make_report(gmd_pkg::ST_ED1, msg_start, '0, '0);
          end else if (hdr_count == 4'd3 && b != gmd_pkg::EDITION) begin
            trk_phase = gmd_pkg::PH_SEEK;
            rescan = 1'b1;
          end else begin
            hdr_count = hdr_count + 4'd1;
          end
        end else begin
          len_acc = {len_acc[55:0], b};
          if (hdr_count >= 4'd11) begin
            trk_phase = gmd_pkg::PH_SEEK;
            if (len_acc < gmd_pkg::MIN_MSG) begin
              got = 1'b1;
              rep = make_report(gmd_pkg::ST_SHORT, msg_start, len_acc, '0);
            end else if (len_acc[63:gmd_pkg::LENGTH_BITS] != '0) begin
              got = 1'b1;
              rep = make_report(gmd_pkg::ST_WIDE, msg_start, '1, '0);
            end else begin
              trk_phase    = gmd_pkg::PH_BODY;
              body_pos     = 64'(gmd_pkg::HDR_SIZE);
              next_sect    = 64'(gmd_pkg::HDR_SIZE);
              sect_len_acc = '0;
              data_sects   = '0;
              walk_fault   = gmd_pkg::ST_NONE;
              tail_ok      = 1'b1;
            end
          end else begin
            hdr_count = hdr_count + 4'd1;
          end
        end
      end
      gmd_pkg::PH_BODY: begin
        o   = body_pos;
        lim = len_acc;
        nx  = next_sect;
        // section walk: four length bytes then the section number
        if (walk_fault == gmd_pkg::ST_NONE && nx < lim - 64'd4 && o >= nx
            && o - nx <= 64'd4) begin
          d = o - nx;
          if (d < 64'd4) begin
            sect_len_acc = (d == 64'd0) ? {24'd0, b} : {sect_len_acc[23:0], b};
          end else begin
            sl = 64'(sect_len_acc);
            if (b == gmd_pkg::SECT_DATA && data_sects != '1) data_sects = data_sects + 1'b1;
            if (sl < 64'(gmd_pkg::SECT_MIN)) walk_fault = gmd_pkg::ST_SHORT_SEC;
            else if (sl > lim - nx) walk_fault = gmd_pkg::ST_OVERRUN;
            else next_sect = nx + sl;
          end
        end
        if (o >= lim - 64'd4 && b != gmd_pkg::CH_END) tail_ok = 1'b0;
        if (o >= lim - 64'd1) begin
          if (!tail_ok) st = gmd_pkg::ST_NO_END;
          else if (walk_fault != gmd_pkg::ST_NONE) st = walk_fault;
          else if (next_sect != lim - 64'd4) st = gmd_pkg::ST_MISALIGN;
          else st = gmd_pkg::ST_OK;
          got = 1'b1;
          rep = make_report(st, msg_start, lim, (st == gmd_pkg::ST_OK) ? data_sects : '0);
          trk_phase = gmd_pkg::PH_SEEK;
        end else begin
          body_pos = o + 64'd1;
        end
      end
      default: hunt_g(b, pos);
    endcase
  endtask

  task automatic predict_report(input gmd_pkg::in_t w);
    bit                              got, rescan, spare_got, spare_rescan;
    gmd_pkg::out_t                   rep, spare;
    logic [7:0]                      again [4];
    logic [gmd_pkg::OFFSET_BITS-1:0] pos, base;
    if (w.end_of_stream) begin
      if (trk_phase == gmd_pkg::PH_BODY) begin
        rep = make_report(gmd_pkg::ST_TRUNC, msg_start, len_acc, '0);
      end else begin
        rep = make_report(gmd_pkg::ST_END, '0, '0, '0);
      end
      due_reports.push_back(rep);
      reports_due_total++;
      tracker_clear();
      return;
    end
    pos        = stream_pos;
    stream_pos = stream_pos + 1'b1;
    scan_byte(w.data_byte, pos, got, rep, rescan);
    // wrong edition: the four header bytes go through the hunt again
    if (rescan) begin
      base  = msg_start;
      again = hdr_bytes;
      for (int k = 0; k < 4; k++)
        scan_byte(again[k], base + gmd_pkg::OFFSET_BITS'(4 + k), spare_got, spare,
                  spare_rescan);
    end
    if (got) begin
      due_reports.push_back(rep);
      reports_due_total++;
    end
  endtask

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return gmd_pkg::CH_G;
      1:       return gmd_pkg::CH_R;
      2:       return gmd_pkg::CH_I;
      3:       return gmd_pkg::CH_B;
      4:       return gmd_pkg::CH_END;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_total();
    if ($urandom_range(0, 5) == 0) return gmd_pkg::MIN_MSG;
    return 64'($urandom_range(25, 90));
  endfunction

  task automatic send_word(input gmd_pkg::in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    predict_report(w);
    words_sent++;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  task automatic send_burst();
    gmd_pkg::in_t w;
    while (burst.size() != 0) begin
      w.data_byte     = burst.pop_front();
      w.end_of_stream = 1'b0;
      send_word(w);
    end
  endtask

  task automatic send_end();
    gmd_pkg::in_t w;
    w.data_byte     = 8'($urandom);
    w.end_of_stream = 1'b1;
    send_word(w);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // header, for edition 2 the length and, if 20..4095, a section chain to the 7777 trailer, then at most one defect
  task automatic send_frame(input logic [63:0] total, input logic [7:0] edition,
                            input flaw_t flaw);
    logic [31:0] rem, sl;
    int          n;
    burst.delete();
    burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             pick_byte(), pick_byte(), pick_byte(), edition};
    if (edition == gmd_pkg::EDITION) begin
      for (int k = 7; k >= 0; k--) burst.push_back(total[8*k +: 8]);
      if (total >= gmd_pkg::MIN_MSG && total < 64'd4096) begin
        rem = total[31:0] - 32'd20;
        while (rem != 0) begin
          if (rem < 32'd5) begin
            repeat (rem) burst.push_back(8'($urandom));
            rem = 0;
          end else begin
            sl = (rem <= 32'd12) ? rem : 32'($urandom_range(5, (rem > 32'd29) ? 24 : rem - 5));
            for (int k = 3; k >= 0; k--) burst.push_back(sl[8*k +: 8]);
            burst.push_back(($urandom_range(0, 1) == 0) ? gmd_pkg::SECT_DATA : pick_byte());
            repeat (sl - 32'd5) burst.push_back(8'($urandom));
            rem = rem - sl;
          end
        end
        repeat (4) burst.push_back(gmd_pkg::CH_END);
        sl = '0;
        case (flaw)
          FLAW_NO_END: begin
            n = int'(total) - 1 - $urandom_range(0, 3);
            burst[n] = gmd_pkg::CH_END ^ 8'($urandom_range(1, 255));
          end
          FLAW_SHORT_SEC: sl = 32'($urandom_range(0, 4));
          FLAW_OVERRUN: begin
            sl = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                 : total[31:0] - 32'd15 + 32'($urandom_range(0, 300));
          end
          FLAW_MISALIGN: sl = total[31:0] - 32'd16 - 32'($urandom_range(0, 3));
          FLAW_CUT: begin
            n = $urandom_range(1, burst.size() - 1);
            while (burst.size() > n) void'(burst.pop_back());
          end
          default: ;
        endcase
        if (flaw inside {FLAW_SHORT_SEC, FLAW_OVERRUN, FLAW_MISALIGN})
          for (int k = 0; k < 4; k++) burst[16 + k] = sl[31 - 8*k -: 8];
      end
    end
    send_burst();
    if (flaw == FLAW_CUT) send_end();
  endtask

  task automatic send_random_message();
    flaw_t flaw;
    flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
    send_frame(rand_total(), gmd_pkg::EDITION, flaw);
  endtask

  task automatic test_mark_hunt();
    send_end();
    // false starts at each mark position, then an edition 1 header
    burst = {8'h00, 8'hFF, gmd_pkg::CH_G, gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_G,
             gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I,
             gmd_pkg::CH_B, 8'h00, 8'hFF, 8'h5A, gmd_pkg::EDITION_ONE};
    send_burst();
  endtask

  task automatic test_edition_rescan();
    // header bytes that spell the mark open a new candidate four bytes on
    burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             8'hA5, 8'h00, 8'h7F, gmd_pkg::EDITION_ONE};
    send_burst();
    burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             8'h00, 8'h00, 8'h00, 8'h03,
             gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             8'h01, 8'h02, gmd_pkg::CH_G, 8'hFF};
    send_burst();
    send_frame(gmd_pkg::MIN_MSG, gmd_pkg::EDITION, FLAW_NONE);
  endtask

  task automatic test_length_limits();
    send_frame(64'd19, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'd0, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'h0000_0100_0000_0000, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(gmd_pkg::MIN_MSG, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'd21, gmd_pkg::EDITION, FLAW_NONE);
    // largest length that fits, cut short by end of stream
    send_frame(64'h0000_00FF_FFFF_FFFF, gmd_pkg::EDITION, FLAW_NONE);
    burst = {8'h00, 8'hFF, 8'h07};
    send_burst();
    send_end();
  endtask

  task automatic test_section_walk();
    send_frame(64'd60, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'd40, gmd_pkg::EDITION, FLAW_NONE);
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_NO_END);
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_SHORT_SEC);
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_OVERRUN);
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_MISALIGN);
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_CUT);
  endtask

  task automatic test_end_of_stream();
    burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I};
    send_burst();
    send_end();
    burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I, gmd_pkg::CH_B,
             8'h00, 8'h00, 8'h00, gmd_pkg::EDITION, 8'h00, 8'h00};
    send_burst();
    send_end();
    // positions restart after end of stream
    send_frame(gmd_pkg::MIN_MSG, gmd_pkg::EDITION, FLAW_NONE);
    send_end();
    send_end();
  endtask

  task automatic test_back_to_back();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (2) send_random_message();
    send_end();
    send_frame(64'd30, gmd_pkg::EDITION, FLAW_NONE);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  task automatic test_hold_off();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    wait_drained();
    hold_request = 1'b1;
    // one result word per few bytes, so the output side backs up into the input
    repeat (8) begin
      send_end();
      send_frame(gmd_pkg::MIN_MSG, gmd_pkg::EDITION_ONE, FLAW_NONE);
    end
    wait_drained();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  task automatic test_random_stream();
    logic [7:0]  ed;
    logic [63:0] total;
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) send_gaps = !send_gaps;
      if ($urandom_range(0, 15) == 0) recv_gaps = !recv_gaps;
      case ($urandom_range(0, 19))
        11, 12: send_frame(gmd_pkg::MIN_MSG, gmd_pkg::EDITION_ONE, FLAW_NONE);
        13: begin
          do begin
            ed = pick_byte();
          end while (ed == gmd_pkg::EDITION || ed == gmd_pkg::EDITION_ONE);
          send_frame(gmd_pkg::MIN_MSG, ed, FLAW_NONE);
        end
        14: begin
          total = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 19))
                  : {32'($urandom) | 32'h100, 32'($urandom)};
          send_frame(total, gmd_pkg::EDITION, FLAW_NONE);
        end
        15, 16: begin
          repeat ($urandom_range(1, 12)) burst.push_back(pick_byte());
          send_burst();
        end
        17: send_end();
        18: begin
          burst = {gmd_pkg::CH_G, gmd_pkg::CH_R, gmd_pkg::CH_I};
          while (burst.size() > $urandom_range(1, 3)) void'(burst.pop_back());
          burst.push_back(pick_byte());
          send_burst();
        end
        19: pause_input($urandom_range(1, 30));
        default: send_random_message();
      endcase
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_length()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : report_check
    gmd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result word: %p", out_data);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.message_offset !== want.message_offset) begin
          $error("message_offset: expected %0d, got %0d",
                 want.message_offset, out_data.message_offset);
          mismatches++;
        end
        if (out_data.message_length !== want.message_length) begin
          $error("message_length: expected %0d, got %0d",
                 want.message_length, out_data.message_length);
          mismatches++;
        end
        if (out_data.submessage_count !== want.submessage_count) begin
          $error("submessage_count: expected %0d, got %0d",
                 want.submessage_count, out_data.submessage_count);
          mismatches++;
        end
        reports_checked++;
        status_hits[want.status]++;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("[grib2_message_deframer] ERROR");
    $finish;
  end

  initial begin : main
    int kinds;
    tracker_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_mark_hunt();
    test_edition_rescan();
    test_length_limits();
    test_section_walk();
    test_end_of_stream();
    test_back_to_back();
    test_hold_off();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    kinds = 0;
    for (int s = 0; s < 16; s++) if (status_hits[s] != 0) kinds++;
    $display("stream of %0d words, %0d of %0d result words checked, %0d input stall cycles",
             words_sent, reports_checked, reports_due_total, input_stall_cycles);
    $display("%0d distinct status codes reported, %0d field mismatches", kinds, mismatches);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("[grib2_message_deframer] OK");
    end else begin
      $display("[grib2_message_deframer] ERROR");
    end
    $finish;
  end

endmodule
